/* sv/cft_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cft_pkg: shared types and constants for the constant fold tracker
// Opcode and type codes, register table size, stage payload and the
// flag table update request.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam int REG_COUNT = 256;
  localparam int IDX_W     = $clog2(REG_COUNT);
  localparam int VAL_W     = 32;

  localparam logic [3:0] FN_ADD   = 4'd0;
  localparam logic [3:0] FN_SUB   = 4'd1;
  localparam logic [3:0] FN_MUL   = 4'd2;
  localparam logic [3:0] FN_AND   = 4'd3;
  localparam logic [3:0] FN_OR    = 4'd4;
  localparam logic [3:0] FN_XOR   = 4'd5;
  localparam logic [3:0] FN_SHL   = 4'd6;
  localparam logic [3:0] FN_SHR   = 4'd7;
  localparam logic [3:0] FN_LOADI = 4'd8;

  localparam logic [2:0] TY_U32 = 3'd0;
  localparam logic [2:0] TY_S32 = 3'd1;
  localparam logic [2:0] TY_B32 = 3'd2;
  localparam logic [2:0] TY_B64 = 3'd3;
  localparam logic [2:0] TY_F64 = 3'd4;

  localparam logic [4:0] SHIFT_MASK = 5'd31;

  // register index of the enable register in the apb map
  localparam logic REG_ENABLE = 1'b0;

  typedef struct packed {
    logic             block_start;
    logic [3:0]       func;
    logic [2:0]       type_code;
    logic             has_imm;
    logic [VAL_W-1:0] imm_value;
    logic             predicated;
    logic             dst_is_reg;
    logic [7:0]       dst_reg;
    logic             src1_is_reg;
    logic [7:0]       src1_reg;
    logic             src2_is_reg;
    logic [7:0]       src2_reg;
  } instr_t;

  typedef struct packed {
    logic             clear_all;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_set;
    logic             clr2_en;
    logic [IDX_W-1:0] clr2_addr;
  } flag_upd_t;

  // register index into the table, aliasing when the table is smaller
  function automatic logic [IDX_W-1:0] to_slot(input logic [7:0] r);
    return IDX_W'(r);
  endfunction

endpackage
`default_nettype wire

/* sv/cft_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cft_ram: generic ram, one write port and two registered read ports
// Read data updates only when the read enable is high.
// ----------------------------------------------------------------------------
module cft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

/* sv/cft_alu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cft_alu: folding alu
// Evaluates one foldable opcode on two 32-bit constants, modulo 2^32.
// ----------------------------------------------------------------------------
module cft_alu (
  input  wire logic [3:0]               func,
  input  wire logic [cft_pkg::VAL_W-1:0] a,
  input  wire logic [cft_pkg::VAL_W-1:0] b,
  output logic                          op_ok,
  output logic      [cft_pkg::VAL_W-1:0] result
);
  import cft_pkg::*;

  logic [4:0] shamt;

  assign shamt = b[4:0] & SHIFT_MASK;

  always_comb begin
    op_ok  = 1'b1;
    result = '0;
    case (func)
      FN_ADD: result = a + b;
      FN_SUB: result = a - b;
      FN_MUL: result = a * b;
      FN_AND: result = a & b;
      FN_OR:  result = a | b;
      FN_XOR: result = a ^ b;
      FN_SHL: result = a << shamt;
      FN_SHR: result = a >> shamt;
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/cft_flags.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cft_flags: known-constant flag table
// One flop per register, cleared by reset or block start, read at two
// source indices.
// ----------------------------------------------------------------------------
module cft_flags (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cft_pkg::flag_upd_t        upd,
  input  wire logic [cft_pkg::IDX_W-1:0] rd_addr1,
  input  wire logic [cft_pkg::IDX_W-1:0] rd_addr2,
  output logic                           rd_flag1,
  output logic                           rd_flag2
);
  import cft_pkg::*;

  logic [REG_COUNT-1:0] flag;
  logic [REG_COUNT-1:0] flag_next;

  assign rd_flag1 = flag[rd_addr1];
  assign rd_flag2 = flag[rd_addr2];

  // block clear first, then the destination, then the upper half clear
  always_comb begin
    flag_next = upd.clear_all ? '0 : flag;
    if (upd.wr_en) begin
      flag_next[upd.wr_addr] = upd.wr_set;
    end
    if (upd.clr2_en) begin
      flag_next[upd.clr2_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= '0;
    end else begin
      flag <= flag_next;
    end
  end

endmodule
`default_nettype wire

/* sv/constant_fold_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// constant_fold_tracker: per-register constant tracking and folding
// Tracks known-constant registers across an instruction stream and folds
// integer operations on two known sources into load-immediates.
// ----------------------------------------------------------------------------
// Takes one instruction request per clock unless the output stalls, and
// returns one result per request: the request is registered together
// with the two source values read from the value ram, then the flag table
// lookup, the alu and the table update happen combinationally before the
// result register. A value written in the same cycle as the following read
// is forwarded past the ram. There is no clearing pass: flags are flops
// cleared by reset, and values are only ever read behind a set flag.
// ----------------------------------------------------------------------------
module constant_fold_tracker (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // apb configuration port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  // instruction requests
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      block_start,
  input  wire logic [3:0]                func,
  input  wire logic [2:0]                type_code,
  input  wire logic                      has_imm,
  input  wire logic [cft_pkg::VAL_W-1:0] imm_value,
  input  wire logic                      predicated,
  input  wire logic                      dst_is_reg,
  input  wire logic [7:0]                dst_reg,
  input  wire logic                      src1_is_reg,
  input  wire logic [7:0]                src1_reg,
  input  wire logic                      src2_is_reg,
  input  wire logic [7:0]                src2_reg,
  // results
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           folded,
  output logic      [cft_pkg::VAL_W-1:0] folded_value,
  output logic                           dst_known
);
  import cft_pkg::*;

  logic             enable;
  logic             in_accept;
  logic             s_valid;
  instr_t           s;
  logic             adv;
  logic             byp_valid;
  logic [IDX_W-1:0] byp_addr;
  logic [VAL_W-1:0] byp_data;
  logic [VAL_W-1:0] rd1;
  logic [VAL_W-1:0] rd2;
  logic [VAL_W-1:0] val1;
  logic [VAL_W-1:0] val2;
  logic [IDX_W-1:0] s1_slot;
  logic [IDX_W-1:0] s2_slot;
  logic [IDX_W-1:0] d_slot;
  logic [IDX_W-1:0] d2_slot;
  logic             flag1;
  logic             flag2;
  logic             alu_ok;
  logic [VAL_W-1:0] alu_res;
  logic             int_type;
  logic             wide_type;
  logic             fold;
  logic             set_dst;
  logic             wr_en;
  logic [VAL_W-1:0] wr_data;
  logic             known;
  flag_upd_t        upd;

  // configuration
  assign pready = 1'b1;
  assign prdata = 32'(enable);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_ENABLE) begin
      enable <= pwdata[0];
    end
  end

  // handshake
  assign adv       = s_valid && (!out_valid || out_ready);
  assign in_ready  = !s_valid || adv;
  assign in_accept = in_valid && in_ready;

  // request stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      byp_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s_valid   <= 1'b1;
        byp_valid <= wr_en;
      end else if (adv) begin
        s_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s.block_start <= block_start;
      s.func        <= func;
      s.type_code   <= type_code;
      s.has_imm     <= has_imm;
      s.imm_value   <= imm_value;
      s.predicated  <= predicated;
      s.dst_is_reg  <= dst_is_reg;
      s.dst_reg     <= dst_reg;
      s.src1_is_reg <= src1_is_reg;
      s.src1_reg    <= src1_reg;
      s.src2_is_reg <= src2_is_reg;
      s.src2_reg    <= src2_reg;
      byp_addr      <= d_slot;
      byp_data      <= wr_data;
    end
  end

  cft_ram #(
    .WIDTH (VAL_W),
    .DEPTH (REG_COUNT)
  ) u_values (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (d_slot),
    .wdata   (wr_data),
    .re      (in_accept),
    .raddr_a (to_slot(src1_reg)),
    .raddr_b (to_slot(src2_reg)),
    .rdata_a (rd1),
    .rdata_b (rd2)
  );

  // forward the write that landed on the same edge as the read
  assign s1_slot = to_slot(s.src1_reg);
  assign s2_slot = to_slot(s.src2_reg);
  assign val1    = (byp_valid && byp_addr == s1_slot) ? byp_data : rd1;
  assign val2    = (byp_valid && byp_addr == s2_slot) ? byp_data : rd2;

  cft_flags u_flags (
    .clk      (clk),
    .rst      (rst),
    .upd      (upd),
    .rd_addr1 (s1_slot),
    .rd_addr2 (s2_slot),
    .rd_flag1 (flag1),
    .rd_flag2 (flag2)
  );

  cft_alu u_alu (
    .func   (s.func),
    .a      (val1),
    .b      (val2),
    .op_ok  (alu_ok),
    .result (alu_res)
  );

  assign d_slot  = to_slot(s.dst_reg);
  assign d2_slot = to_slot(s.dst_reg + 8'd1);

  always_comb begin
    int_type  = s.type_code inside {TY_U32, TY_S32, TY_B32};
    wide_type = s.type_code inside {TY_B64, TY_F64};
    // a block start hides every flag from this request's own lookup
    fold = enable && !s.block_start && int_type && !s.has_imm && s.dst_is_reg &&
           s.src1_is_reg && s.src2_is_reg && flag1 && flag2 && alu_ok;
    set_dst = (fold || (s.func == FN_LOADI && s.has_imm)) && !s.predicated;
    wr_data = fold ? alu_res : s.imm_value;
    wr_en   = adv && enable && s.dst_is_reg && set_dst;
    known   = enable && s.dst_is_reg && set_dst && !(wide_type && d2_slot == d_slot);

    upd.clear_all = adv && enable && s.block_start;
    upd.wr_en     = adv && enable && s.dst_is_reg;
    upd.wr_addr   = d_slot;
    upd.wr_set    = set_dst;
    upd.clr2_en   = adv && enable && s.dst_is_reg && wide_type;
    upd.clr2_addr = d2_slot;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      folded       <= fold;
      folded_value <= fold ? alu_res : '0;
      dst_known    <= known;
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s_valid && out_valid && !out_ready)
    else $error("request refused while a stage is free");

  a_adv_gives_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("advanced request produced no result");

  a_unfolded_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !folded |-> folded_value == '0)
    else $error("value reported without a fold");

  a_single_writer: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> adv && upd.wr_en && upd.wr_set)
    else $error("value write without a matching flag set");

endmodule
`default_nettype wire

/* dv/constant_fold_tracker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// constant_fold_tracker_tb: self-checking bench for the constant fold tracker
// Walks a short table of directed instructions, then long runs of random
// instruction streams with folding switched on and off over the apb port.
// Each result is checked against its directed row or a fold/track predictor
// kept in the bench, with bursty input requests and patterned output stalls.
// ----------------------------------------------------------------------------
module constant_fold_tracker_tb;
  import cft_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 5;

  typedef struct packed {
    logic             folded;
    logic [VAL_W-1:0] value;
    logic             known;
  } fold_res_t;

  typedef struct {
    instr_t    ins;
    bit        typed;
    fold_res_t res;
  } dir_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_QUARTER, RX_SPARSE} rx_pattern_e;

  logic        clk;
  logic        rst     = 1'b1;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  wire  [31:0] prdata;
  wire         pready;
  logic        in_valid  = 1'b0;
  wire         in_ready;
  instr_t      stim      = '0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire         folded;
  wire  [VAL_W-1:0] folded_value;
  wire         dst_known;

  // predictor copy of the tracker state
  logic             known_tbl [REG_COUNT];
  logic [VAL_W-1:0] value_tbl [REG_COUNT];
  logic             en_cfg = 1'b1;

  fold_res_t   expected_folds [$];
  dir_row_t    dir_rows [$];
  int          err_count    = 0;
  int          cycle_count  = 0;
  int          n_sent       = 0;
  int          n_disabled   = 0;
  int          n_results    = 0;
  int          n_folds      = 0;
  int          n_known      = 0;
  int          n_cfg        = 0;
  int          burst_left   = 0;
  int          mode_left    = 0;
  int          rx_phase     = 0;
  rx_pattern_e rx_mode      = RX_OPEN;
  logic [31:0] cfg_word;
  bit          phase_en  [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  int          phase_len [NUM_PHASES] = '{450, 125, 450, 125, 425};

  constant_fold_tracker dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .block_start  (stim.block_start),
    .func         (stim.func),
    .type_code    (stim.type_code),
    .has_imm      (stim.has_imm),
    .imm_value    (stim.imm_value),
    .predicated   (stim.predicated),
    .dst_is_reg   (stim.dst_is_reg),
    .dst_reg      (stim.dst_reg),
    .src1_is_reg  (stim.src1_is_reg),
    .src1_reg     (stim.src1_reg),
    .src2_is_reg  (stim.src2_is_reg),
    .src2_reg     (stim.src2_reg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .folded       (folded),
    .folded_value (folded_value),
    .dst_known    (dst_known)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int tbl_slot(input logic [7:0] r);
    return int'(r) % REG_COUNT;
  endfunction

  // one instruction through the fold/track predictor, state updated in place
  function automatic fold_res_t fold_and_track(input instr_t ins);
    fold_res_t        r;
    logic [VAL_W-1:0] a, b, v, iv;
    logic [3:0]       fn;
    logic             hi, is_int, can;
    int               d;
    r = '0;
    if (!en_cfg) return r;
    if (ins.block_start) begin
      foreach (known_tbl[i]) known_tbl[i] = 1'b0;
    end
    fn = ins.func;
    hi = ins.has_imm;
    iv = ins.imm_value;
    is_int = (ins.type_code == TY_U32) || (ins.type_code == TY_S32) ||
             (ins.type_code == TY_B32);
    if (is_int && !hi && ins.dst_is_reg && ins.src1_is_reg && ins.src2_is_reg &&
        known_tbl[tbl_slot(ins.src1_reg)] && known_tbl[tbl_slot(ins.src2_reg)]) begin
      a = value_tbl[tbl_slot(ins.src1_reg)];
      b = value_tbl[tbl_slot(ins.src2_reg)];
      can = 1'b1;
      v = '0;
      case (fn)
        FN_ADD: v = a + b;
        FN_SUB: v = a - b;
        FN_MUL: v = a * b;
        FN_AND: v = a & b;
        FN_OR:  v = a | b;
        FN_XOR: v = a ^ b;
        FN_SHL: v = a << (b[4:0] & SHIFT_MASK);
        FN_SHR: v = a >> (b[4:0] & SHIFT_MASK);
        default: can = 1'b0;
      endcase
      if (can) begin
        r.folded = 1'b1;
        r.value  = v;
        fn = FN_LOADI;
        hi = 1'b1;
        iv = v;
      end
    end
    if (ins.dst_is_reg) begin
      d = tbl_slot(ins.dst_reg);
      if (fn == FN_LOADI && hi && !ins.predicated) begin
        known_tbl[d] = 1'b1;
        value_tbl[d] = iv;
      end else begin
        known_tbl[d] = 1'b0;
      end
      // wide types also take the next register, wrapping at 255
      if (ins.type_code == TY_B64 || ins.type_code == TY_F64)
        known_tbl[tbl_slot(8'(ins.dst_reg + 8'd1))] = 1'b0;
      r.known = known_tbl[d];
    end
    return r;
  endfunction

  function automatic instr_t mk(input logic bs, input logic [3:0] fn, input logic [2:0] ty,
                                input logic hi, input logic [31:0] imm, input logic pr,
                                input logic [7:0] d, input logic [7:0] s1,
                                input logic [7:0] s2);
    instr_t t;
    t = '0;
    t.block_start = bs;
    t.func        = fn;
    t.type_code   = ty;
    t.has_imm     = hi;
    t.imm_value   = imm;
    t.predicated  = pr;
    t.dst_is_reg  = 1'b1;
    t.dst_reg     = d;
    t.src1_is_reg = 1'b1;
    t.src1_reg    = s1;
    t.src2_is_reg = 1'b1;
    t.src2_reg    = s2;
    return t;
  endfunction

  // mostly a small pool so sources are often known, with the top end for wrap
  function automatic logic [7:0] pick_reg();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 8'($urandom);
    if (k < 3) return 8'(252 + $urandom_range(0, 3));
    return 8'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] pick_imm();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'($urandom_range(0, 40));
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t rand_instr();
    instr_t t;
    int     k;
    k = $urandom_range(0, 99);
    t = mk($urandom_range(0, 39) == 0, FN_LOADI, TY_U32, 1'b1, pick_imm(),
           $urandom_range(0, 9) == 0, pick_reg(), pick_reg(), pick_reg());
    if (k < 30) begin
      t.type_code = 3'($urandom_range(0, 4));
    end else if (k < 75) begin
      t.func      = 4'($urandom_range(0, 7));
      t.type_code = 3'($urandom_range(0, 2));
      t.has_imm   = 1'b0;
    end else begin
      t.block_start = $urandom_range(0, 7) == 0;
      t.func        = 4'($urandom);
      t.type_code   = 3'($urandom);
      t.has_imm     = 1'($urandom);
      t.imm_value   = $urandom;
      t.predicated  = 1'($urandom);
      t.dst_is_reg  = 1'($urandom);
      t.dst_reg     = 8'($urandom);
      t.src1_is_reg = 1'($urandom);
      t.src1_reg    = 8'($urandom);
      t.src2_is_reg = 1'($urandom);
      t.src2_reg    = 8'($urandom);
    end
    return t;
  endfunction

  function automatic void add_row(input instr_t t, input bit typed, input fold_res_t r);
    dir_row_t row;
    row.ins   = t;
    row.typed = typed;
    row.res   = r;
    dir_rows.push_back(row);
  endfunction

  // bursty sender: random idle gaps between bursts of random length
  task automatic send_item(input instr_t t, input bit typed, input fold_res_t tres);
    fold_res_t p;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid <= 1'b1;
    stim     <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!en_cfg) n_disabled++;
    p = fold_and_track(t);
    expected_folds.push_back(typed ? tres : p);
    n_sent++;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (expected_folds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_enable(input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * int'(REG_ENABLE));
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    en_cfg = data[0];
    n_cfg++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // receiver stall pattern, switched at random intervals
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = rx_pattern_e'($urandom_range(0, 3));
      mode_left = $urandom_range(32, 200);
    end
    mode_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_COIN:    out_ready <= 1'($urandom);
      RX_QUARTER: out_ready <= (rx_phase % 4) == 0;
      default:    out_ready <= $urandom_range(0, 7) != 0;
    endcase
  end

  always @(posedge clk) begin : result_check
    fold_res_t e;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (folded) n_folds++;
      if (dst_known) n_known++;
      if (expected_folds.size() == 0) begin
        $error("result with no request outstanding");
        err_count++;
      end else begin
        e = expected_folds.pop_front();
        if (folded !== e.folded) begin
          $error("folded: expected %0d, got %0d", e.folded, folded);
          err_count++;
        end
        if (folded_value !== e.value) begin
          $error("folded_value: expected %08h, got %08h", e.value, folded_value);
          err_count++;
        end
        if (dst_known !== e.known) begin
          $error("dst_known: expected %0d, got %0d", e.known, dst_known);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_folds.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    foreach (known_tbl[i]) begin
      known_tbl[i] = 1'b0;
      value_tbl[i] = '0;
    end

    // directed table, enable still at its reset value
    add_row(mk(0, FN_LOADI, TY_U32, 1, 32'hffff_ffff, 0, 8'd0, 8'd0, 8'd0), 1, '{0, 0, 1});
    add_row(mk(0, FN_LOADI, TY_U32, 1, 32'h0, 0, 8'd255, 8'd0, 8'd0), 1, '{0, 0, 1});
    add_row(mk(0, FN_LOADI, TY_U32, 1, 32'h8000_0001, 0, 8'd1, 8'd0, 8'd0), 1, '{0, 0, 1});
    add_row(mk(0, FN_ADD, TY_S32, 0, 32'h0, 0, 8'd2, 8'd0, 8'd1), 0, '0);
    add_row(mk(0, FN_SUB, TY_B32, 0, 32'h0, 0, 8'd3, 8'd255, 8'd0), 0, '0);
    add_row(mk(0, FN_MUL, TY_U32, 0, 32'h0, 0, 8'd4, 8'd0, 8'd1), 0, '0);
    add_row(mk(0, FN_AND, TY_U32, 0, 32'h0, 0, 8'd5, 8'd0, 8'd1), 0, '0);
    add_row(mk(0, FN_OR, TY_U32, 0, 32'h0, 0, 8'd6, 8'd255, 8'd1), 0, '0);
    add_row(mk(0, FN_XOR, TY_U32, 0, 32'h0, 0, 8'd7, 8'd0, 8'd1), 0, '0);
    // shift amounts taken from all-ones, so masked to 31
    add_row(mk(0, FN_SHL, TY_U32, 0, 32'h0, 0, 8'd8, 8'd1, 8'd0), 0, '0);
    add_row(mk(0, FN_SHR, TY_U32, 0, 32'h0, 0, 8'd9, 8'd0, 8'd0), 0, '0);
    add_row(mk(0, FN_LOADI, TY_U32, 1, 32'd5, 1, 8'd10, 8'd0, 8'd0), 1, '{0, 0, 0});
    // guarded fold still folds but leaves the destination unknown
    add_row(mk(0, FN_ADD, TY_U32, 0, 32'h0, 1, 8'd11, 8'd0, 8'd1), 0, '0);
    add_row(mk(0, FN_ADD, TY_U32, 1, 32'd9, 0, 8'd12, 8'd0, 8'd1), 1, '{0, 0, 0});
    add_row(mk(0, 4'd9, TY_U32, 0, 32'h0, 0, 8'd13, 8'd0, 8'd1), 1, '{0, 0, 0});
    add_row(mk(0, 4'd15, TY_U32, 0, 32'h0, 0, 8'd14, 8'd0, 8'd1), 1, '{0, 0, 0});
    add_row(mk(0, FN_ADD, 3'd5, 0, 32'h0, 0, 8'd15, 8'd0, 8'd1), 1, '{0, 0, 0});
    add_row(mk(0, FN_ADD, 3'd7, 0, 32'h0, 0, 8'd16, 8'd0, 8'd1), 1, '{0, 0, 0});
    // wide load at 254 knocks out 255
    add_row(mk(0, FN_LOADI, TY_B64, 1, 32'd7, 0, 8'd254, 8'd0, 8'd0), 1, '{0, 0, 1});
    add_row(mk(0, FN_ADD, TY_U32, 0, 32'h0, 0, 8'd17, 8'd254, 8'd255), 1, '{0, 0, 0});
    // wide load at 255 wraps round onto register 0
    add_row(mk(0, FN_LOADI, TY_F64, 1, 32'd3, 0, 8'd255, 8'd0, 8'd0), 1, '{0, 0, 1});
    add_row(mk(0, FN_ADD, TY_U32, 0, 32'h0, 0, 8'd18, 8'd0, 8'd1), 1, '{0, 0, 0});
    add_row(mk(0, FN_ADD, TY_U32, 0, 32'h0, 0, 8'd0, 8'd1, 8'd1), 1, '{0, 0, 0});
    dir_rows[$].ins.dst_is_reg = 1'b0;
    add_row(mk(0, FN_ADD, TY_U32, 0, 32'h0, 0, 8'd19, 8'd1, 8'd1), 1, '{0, 0, 0});
    dir_rows[$].ins.src1_is_reg = 1'b0;
    // block start clears before the lookup
    add_row(mk(1, FN_ADD, TY_U32, 0, 32'h0, 0, 8'd20, 8'd1, 8'd1), 1, '{0, 0, 0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].ins, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_and_settle();
      cfg_word    = $urandom;
      cfg_word[0] = phase_en[p];
      write_enable(cfg_word);
      repeat (phase_len[p]) send_item(rand_instr(), 1'b0, '0);
    end

    drain_and_settle();
    repeat (10) @(posedge clk);
    $display("covered %0d requests (%0d with folding off) over %0d enable writes",
             n_sent, n_disabled, n_cfg);
    $display("saw %0d results: %0d folded, %0d with a known destination",
             n_results, n_folds, n_known);
    if (err_count == 0 && expected_folds.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
